### hw/rtl/hct_pkg.sv
package hct_pkg;

  // table geometry
  localparam int NODES  = 64;
  localparam int NODE_W = 6;
  localparam int CNT_W  = 64;
  localparam int LVL_W  = 7;

  // beat widths: fields packed from bit 0, padded to whole bytes
  localparam int IN_FIELDS_W  = 2 * NODE_W + 2 + CNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CNT_W + LVL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OP_W         = 3;

  // operation codes; the two unused codes act as read
  typedef enum logic [OP_W-1:0] {
    OP_DEFINE    = 3'd0,
    OP_ADD       = 3'd1,
    OP_SUB       = 3'd2,
    OP_SET       = 3'd3,
    OP_RESET_ALL = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  // per-node link and flags, stored in one RAM word
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic              is_root;
    logic              absolute;
  } meta_t;

  localparam meta_t META_RESET = '{parent: '0, is_root: 1'b1, absolute: 1'b0};

endpackage

### hw/rtl/hct_ram.sv
module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hierarchical_counter_table.sv
// Steps from accepted beat to result valid: define writes and goes straight to DONE, read
// and set read the RAM once in PROC, add/subtract do one RAM read-modify-write per counter
// on the parent walk, reset-all sweeps the table one entry a cycle; DONE registers the result.
// One item in work at a time; in_tready returns in the same cycle that the result is
// registered, and DONE waits while the output register is held by a stall.
// Reset (rst_n low, synchronous) clears control and the per-entry valid bits only.
module hierarchical_counter_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node[5:0], parent_node[11:6], is_root[12], absolute[13], value[77:14], zero pad
  input  logic [hct_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[2:0]
  input  logic [hct_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // count[63:0], levels_touched[70:64], zero pad
  output logic [hct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_SWEEP,
    ST_SWTAIL,
    ST_DONE
  } state_t;

  localparam int NW = hct_pkg::NODE_W;
  localparam int CW = hct_pkg::CNT_W;
  localparam int LW = hct_pkg::LVL_W;
  localparam int MW = $bits(hct_pkg::meta_t);
  localparam int OUT_TDATA_W_L = hct_pkg::OUT_TDATA_W;

  // input beat fields
  logic [NW-1:0] in_node;
  logic [NW-1:0] in_parent;
  logic          in_root;
  logic          in_abs;
  logic [CW-1:0] in_value;
  logic          in_acc;

  assign in_node   = in_tdata[NW-1:0];
  assign in_parent = in_tdata[2*NW-1:NW];
  assign in_root   = in_tdata[2*NW];
  assign in_abs    = in_tdata[2*NW+1];
  assign in_value  = in_tdata[2*NW+2+CW-1:2*NW+2];

  state_t                   state_r, state_nxt;
  logic [hct_pkg::OP_W-1:0] op_r, op_nxt;
  logic [NW-1:0]            node_r, node_nxt;
  logic [CW-1:0]            value_r, value_nxt;
  logic [LW-1:0]            steps_r, steps_nxt;
  logic [CW-1:0]            res_cnt_r, res_cnt_nxt;
  logic [LW-1:0]            res_lvl_r, res_lvl_nxt;
  logic [NW-1:0]            sw_idx_r, sw_idx_nxt;
  logic [LW-1:0]            sw_cnt_r, sw_cnt_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W_L-1:0] out_tdata_r, out_tdata_nxt;

  // RAM ports
  logic                 cnt_we, meta_we;
  logic [NW-1:0]        cnt_waddr, meta_waddr, raddr;
  logic [CW-1:0]        cnt_wdata, cnt_rdata;
  hct_pkg::meta_t       meta_wdata, meta_rdata;
  logic [MW-1:0]        meta_rdata_raw;

  // read address of the data now on the RAM outputs
  logic [NW-1:0]        rd_addr_q_r;

  // per-entry valid bits and one-deep write forwarding
  logic [hct_pkg::NODES-1:0] cnt_vld_r, meta_vld_r;
  logic                      fwd_vld_r;
  logic [NW-1:0]             fwd_addr_r;
  logic [CW-1:0]             fwd_data_r;

  // current entry as seen by the walk
  logic [CW-1:0]  cnt_cur;
  hct_pkg::meta_t meta_cur;
  logic [CW-1:0]  cnt_upd;
  logic           walk_stop;
  logic [LW-1:0]  steps_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  hct_ram #(.WIDTH(CW), .DEPTH(hct_pkg::NODES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  hct_ram #(.WIDTH(MW), .DEPTH(hct_pkg::NODES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_rdata_raw)
  );

  assign meta_rdata = hct_pkg::meta_t'(meta_rdata_raw);

  // masked read data: unwritten entries read as reset values, last counter write forwarded
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_q_r)) begin
      cnt_cur = fwd_data_r;
    end else if (cnt_vld_r[rd_addr_q_r]) begin
      cnt_cur = cnt_rdata;
    end else begin
      cnt_cur = '0;
    end
    meta_cur = meta_vld_r[rd_addr_q_r] ? meta_rdata : hct_pkg::META_RESET;
    cnt_upd  = (op_r == hct_pkg::OP_SUB) ? cnt_cur - value_r : cnt_cur + value_r;
    steps_inc = steps_r + LW'(1);
    walk_stop = meta_cur.absolute || meta_cur.is_root ||
                (steps_inc == LW'(hct_pkg::NODES));
  end

  // sequencer and write-port control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    node_nxt       = node_r;
    value_nxt      = value_r;
    steps_nxt      = steps_r;
    res_cnt_nxt    = res_cnt_r;
    res_lvl_nxt    = res_lvl_r;
    sw_idx_nxt     = sw_idx_r;
    sw_cnt_nxt     = sw_cnt_r;
    chk_vld_nxt    = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    raddr          = in_node;
    cnt_we         = 1'b0;
    cnt_waddr      = rd_addr_q_r;
    cnt_wdata      = '0;
    meta_we        = 1'b0;
    meta_waddr     = in_node;
    meta_wdata     = '{parent: in_parent, is_root: in_root, absolute: in_abs};

    // output register drains independently
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // sweep check stage: clear counters that are not absolute
    if (chk_vld_r && !meta_cur.absolute) begin
      cnt_we     = 1'b1;
      cnt_waddr  = rd_addr_q_r;
      cnt_wdata  = '0;
      sw_cnt_nxt = sw_cnt_r + LW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          node_nxt  = in_node;
          value_nxt = in_value;
          steps_nxt = '0;
          case (in_tuser)
            hct_pkg::OP_DEFINE: begin
              meta_we     = 1'b1;
              cnt_we      = 1'b1;
              cnt_waddr   = in_node;
              cnt_wdata   = '0;
              res_cnt_nxt = '0;
              res_lvl_nxt = LW'(1);
              state_nxt   = ST_DONE;
            end
            hct_pkg::OP_RESET_ALL: begin
              sw_idx_nxt = '0;
              sw_cnt_nxt = '0;
              state_nxt  = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_PROC;
            end
          endcase
        end
      end

      ST_PROC: begin
        case (op_r)
          hct_pkg::OP_ADD, hct_pkg::OP_SUB: begin
            cnt_we    = 1'b1;
            cnt_waddr = rd_addr_q_r;
            cnt_wdata = cnt_upd;
            steps_nxt = steps_inc;
            if (rd_addr_q_r == node_r) begin
              res_cnt_nxt = cnt_upd;
            end
            if (walk_stop) begin
              res_lvl_nxt = steps_inc;
              state_nxt   = ST_DONE;
            end else begin
              raddr = meta_cur.parent;
            end
          end
          hct_pkg::OP_SET: begin
            if (meta_cur.absolute) begin
              cnt_we      = 1'b1;
              cnt_waddr   = rd_addr_q_r;
              cnt_wdata   = value_r;
              res_cnt_nxt = value_r;
              res_lvl_nxt = LW'(1);
            end else begin
              res_cnt_nxt = cnt_cur;
              res_lvl_nxt = '0;
            end
            state_nxt = ST_DONE;
          end
          default: begin
            res_cnt_nxt = cnt_cur;
            res_lvl_nxt = '0;
            state_nxt   = ST_DONE;
          end
        endcase
      end

      ST_SWEEP: begin
        raddr       = sw_idx_r;
        chk_vld_nxt = 1'b1;
        sw_idx_nxt  = sw_idx_r + NW'(1);
        if (sw_idx_r == NW'(hct_pkg::NODES - 1)) begin
          state_nxt = ST_SWTAIL;
        end
      end

      ST_SWTAIL: begin
        res_cnt_nxt = '0;
        res_lvl_nxt = sw_cnt_nxt;
        state_nxt   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W_L'({res_lvl_r, res_cnt_r});
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, registered outputs and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      fwd_vld_r    <= 1'b0;
      cnt_vld_r    <= '0;
      meta_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      fwd_vld_r    <= cnt_we;
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      if (meta_we) begin
        meta_vld_r[meta_waddr] <= 1'b1;
      end
    end
    op_r        <= op_nxt;
    node_r      <= node_nxt;
    value_r     <= value_nxt;
    steps_r     <= steps_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_lvl_r   <= res_lvl_nxt;
    sw_idx_r    <= sw_idx_nxt;
    sw_cnt_r    <= sw_cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    rd_addr_q_r <= raddr;
    fwd_addr_r  <= cnt_waddr;
    fwd_data_r  <= cnt_wdata;
  end

endmodule

### tb/hct_checker.sv
`timescale 1ns / 1ps
module hct_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [hct_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [hct_pkg::OP_W-1:0]        in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [hct_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              results_due
);

  localparam int NODES  = hct_pkg::NODES;
  localparam int NODE_W = hct_pkg::NODE_W;
  localparam int CNT_W  = hct_pkg::CNT_W;
  localparam int LVL_W  = hct_pkg::LVL_W;
  localparam int OP_W   = hct_pkg::OP_W;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [LVL_W-1:0] levels;
  } tally_result_t;

  // shadow of the counter table
  logic [CNT_W-1:0]  tally     [NODES];
  logic [NODE_W-1:0] uplink    [NODES];
  logic              root_mark [NODES];
  logic              abs_flag  [NODES];

  tally_result_t counts_due[$];

  function automatic logic [LVL_W-1:0] clamp_levels(input int n);
    return (n > 127) ? LVL_W'(127) : LVL_W'(n);
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
    $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // apply one operation to the shadow table and return the result it gives
  task automatic predict_op(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                            input logic [NODE_W-1:0] parent, input logic root,
                            input logic abso, input logic [CNT_W-1:0] value,
                            output tally_result_t res);
    int steps;
    int cleared;
    int cur;
    res     = '0;
    steps   = 0;
    cleared = 0;
    if (op == hct_pkg::OP_RESET_ALL) begin
      for (int i = 0; i < NODES; i++) begin
        if (!abs_flag[i]) begin
          tally[i] = '0;
          cleared++;
        end
      end
      res.levels = clamp_levels(cleared);
    end else begin
      case (op)
        hct_pkg::OP_DEFINE: begin
          uplink[node]    = parent;
          root_mark[node] = root;
          abs_flag[node]  = abso;
          tally[node]     = '0;
          steps           = 1;
        end
        hct_pkg::OP_ADD, hct_pkg::OP_SUB: begin
          // walk up the parent chain; the step bound breaks link loops.
          // a 6-bit parent index can never point past the table
          cur = node;
          while (steps < NODES) begin
            if (op == hct_pkg::OP_SUB) tally[cur] = tally[cur] - value;
            else tally[cur] = tally[cur] + value;
            steps++;
            if (abs_flag[cur] || root_mark[cur]) break;
            cur = uplink[cur];
          end
        end
        hct_pkg::OP_SET: begin
          if (abs_flag[node]) begin
            tally[node] = value;
            steps       = 1;
          end
        end
        default: ;  // read and the spare codes leave the table alone
      endcase
      res.count  = tally[node];
      res.levels = clamp_levels(steps);
    end
  endtask

  always @(posedge clk) begin
    tally_result_t want;
    tally_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        tally[i]     = '0;
        uplink[i]    = '0;
        root_mark[i] = 1'b1;
        abs_flag[i]  = 1'b0;
      end
      counts_due.delete();
      mismatches = 0;
    end else begin
      // result beat: compare against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.count  = out_tdata[CNT_W-1:0];
        got.levels = out_tdata[CNT_W +: LVL_W];
        if (counts_due.size() == 0) begin
          report_mismatch("unexpected result beat", '0, got.count);
        end else begin
          want = counts_due.pop_front();
          if (got.count !== want.count)
            report_mismatch("count", want.count, got.count);
          if (got.levels !== want.levels)
            report_mismatch("levels_touched", CNT_W'(want.levels), CNT_W'(got.levels));
        end
      end
      // input beat: predict its result
      if (in_tvalid && in_tready) begin
        predict_op(in_tuser, in_tdata[NODE_W-1:0], in_tdata[2*NODE_W-1:NODE_W],
                   in_tdata[2*NODE_W], in_tdata[2*NODE_W+1],
                   in_tdata[2*NODE_W+2 +: CNT_W], want);
        counts_due.push_back(want);
      end
    end
    results_due = counts_due.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int NODES  = hct_pkg::NODES;
  localparam int NODE_W = hct_pkg::NODE_W;
  localparam int CNT_W  = hct_pkg::CNT_W;
  localparam int OP_W   = hct_pkg::OP_W;

  localparam int HOLD_CYCLES      = 400;
  localparam int WD_LIMIT         = 3000;
  localparam int TAIL_CYCLES      = 150;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int PRESSURE_ITEMS   = 12;

  // spare op codes, handled as read
  localparam logic [OP_W-1:0]  OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_7 = 3'd7;
  localparam logic [CNT_W-1:0] ALL_ONES   = '1;
  localparam logic [CNT_W-1:0] TOP_BIT    = 64'h8000_0000_0000_0000;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hct_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [OP_W-1:0]                 in_tuser  = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hct_pkg::OUT_TDATA_W-1:0] out_tdata;

  int   mismatches;
  int   results_due;
  logic hold_go      = 1'b0;
  int   hold_left    = 0;
  int   rx_stall_pct = 0;
  int   tx_idle_pct  = 0;
  int   quiet        = 0;

  always #5 clk = ~clk;

  hierarchical_counter_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hct_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == WD_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WD_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                           input logic [NODE_W-1:0] parent, input logic root,
                           input logic abso, input logic [CNT_W-1:0] value);
    logic [hct_pkg::IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[NODE_W-1:0]            = node;
    beat[2*NODE_W-1:NODE_W]     = parent;
    beat[2*NODE_W]              = root;
    beat[2*NODE_W+1]            = abso;
    beat[2*NODE_W+2 +: CNT_W]   = value;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    in_tuser  <= op;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 64'd1;
      1:       return ALL_ONES;
      2:       return TOP_BIT;
      3, 4:    return CNT_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly small node numbers so chains overlap; defines favor lower parents
  task automatic send_random();
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic [CNT_W-1:0]  value;
    int                roll;
    roll  = $urandom_range(99);
    value = pick_value();
    node  = ($urandom_range(4) == 0) ? NODE_W'($urandom_range(NODES-1))
                                     : NODE_W'($urandom_range(15));
    if (node != 0 && $urandom_range(3) != 0) parent = NODE_W'($urandom_range(node - 1));
    else parent = NODE_W'($urandom_range(NODES-1));
    if (roll < 16) op = hct_pkg::OP_DEFINE;
    else if (roll < 40) op = hct_pkg::OP_ADD;
    else if (roll < 46) begin
      op    = hct_pkg::OP_ADD;
      value = 64'd1;
    end else if (roll < 62) op = hct_pkg::OP_SUB;
    else if (roll < 66) begin
      op    = hct_pkg::OP_SUB;
      value = 64'd1;
    end else if (roll < 76) op = hct_pkg::OP_SET;
    else if (roll < 80) op = hct_pkg::OP_RESET_ALL;
    else if (roll < 94) op = hct_pkg::OP_READ;
    else op = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
    send_beat(op, node, parent, ($urandom_range(3) == 0), ($urandom_range(4) == 0), value);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, wrap-around, chains, absolute stop, loops
    send_beat(hct_pkg::OP_READ,      6'd0,  6'd0,  1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_READ,      6'd63, 6'd63, 1'b1, 1'b1, ALL_ONES);
    send_beat(hct_pkg::OP_ADD,       6'd5,  6'd0,  1'b0, 1'b0, ALL_ONES);
    send_beat(hct_pkg::OP_ADD,       6'd5,  6'd0,  1'b0, 1'b0, 64'd1);
    send_beat(hct_pkg::OP_SUB,       6'd5,  6'd0,  1'b0, 1'b0, 64'd1);
    send_beat(hct_pkg::OP_DEFINE,    6'd1,  6'd63, 1'b1, 1'b0, '0);
    send_beat(hct_pkg::OP_DEFINE,    6'd2,  6'd1,  1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_DEFINE,    6'd3,  6'd2,  1'b0, 1'b1, '0);
    send_beat(hct_pkg::OP_DEFINE,    6'd4,  6'd3,  1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_ADD,       6'd4,  6'd0,  1'b0, 1'b0, 64'd100);
    send_beat(hct_pkg::OP_ADD,       6'd2,  6'd0,  1'b0, 1'b0, 64'd7);
    // set on a node without the absolute flag is a no-op
    send_beat(hct_pkg::OP_SET,       6'd2,  6'd0,  1'b0, 1'b0, 64'd55);
    send_beat(hct_pkg::OP_SET,       6'd3,  6'd0,  1'b0, 1'b0, ALL_ONES);
    // two-node loop, then a node that points at itself
    send_beat(hct_pkg::OP_DEFINE,    6'd63, 6'd62, 1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_DEFINE,    6'd62, 6'd63, 1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_ADD,       6'd63, 6'd0,  1'b0, 1'b0, 64'd3);
    send_beat(hct_pkg::OP_DEFINE,    6'd10, 6'd10, 1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_SUB,       6'd10, 6'd0,  1'b0, 1'b0, 64'd2);
    send_beat(hct_pkg::OP_RESET_ALL, 6'd0,  6'd0,  1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_READ,      6'd3,  6'd0,  1'b0, 1'b0, '0);
    send_beat(OP_SPARE_6,            6'd3,  6'd0,  1'b0, 1'b0, ALL_ONES);
    send_beat(OP_SPARE_7,            6'd62, 6'd0,  1'b0, 1'b0, '0);
    send_beat(hct_pkg::OP_DEFINE,    6'd40, 6'd63, 1'b1, 1'b1, ALL_ONES);
    send_beat(hct_pkg::OP_SET,       6'd40, 6'd0,  1'b0, 1'b0, TOP_BIT);
    send_beat(hct_pkg::OP_SUB,       6'd40, 6'd0,  1'b0, 1'b0, ALL_ONES);

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  = 68;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 68;
        end
        default: begin
          tx_idle_pct  = 22;
          rx_stall_pct <= 22;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
    end

    // backpressure: receiver holds off while beats keep coming
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    in_tvalid    <= 1'b0;
    hold_go      <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (PRESSURE_ITEMS) send_random();

    // drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/hct_pkg.sv
hw/rtl/hct_ram.sv
hw/rtl/hierarchical_counter_table.sv
tb/hct_checker.sv
tb/tb.sv
